@@ rtl/core/asd_pkg.sv @@
// Shared types, constants and helper functions of the accelerometer step detector.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package asd_pkg;

    localparam int WINDOW_LEN_DEF = 5;

    // Squared magnitude and window mean are both 32 bits wide.
    localparam int MAG_W   = 32;
    localparam int QUO_W   = 32;
    localparam int COUNT_W = 31;

    // 384 * 384, about 1.5 g squared in raw sensor units.
    localparam logic [31:0] THRESHOLD_RESET = 32'd147456;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_ADJUST = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] adjust_amount;
    } asd_ctl_t;

    // Width of the running window sum: enough for WINDOW_LEN full-scale magnitudes.
    function automatic int sum_width(input int n);
        return MAG_W + $clog2(n);
    endfunction

endpackage

@@ rtl/core/asd_front.sv @@
// Front end: input register, squaring stage and the sliding window with its running sum.
// Depends on asd_pkg.
`timescale 1ns / 1ps

module asd_front #(
    parameter int WINDOW_LEN = asd_pkg::WINDOW_LEN_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  asd_pkg::asd_ctl_t                            in_ctl,
    input  logic signed [15:0]                           accel_x,
    input  logic signed [15:0]                           accel_y,
    input  logic signed [15:0]                           accel_z,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output asd_pkg::asd_ctl_t                            out_ctl,
    output logic [asd_pkg::sum_width(WINDOW_LEN)-1:0]    out_dividend
);
    import asd_pkg::*;

    localparam int SUM_W = sum_width(WINDOW_LEN);
    // Adding half the window length before the divide gives the rounded mean.
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(WINDOW_LEN / 2);

    logic               a_valid_reg;
    asd_ctl_t           a_ctl_reg;
    logic signed [15:0] a_x_reg;
    logic signed [15:0] a_y_reg;
    logic signed [15:0] a_z_reg;

    logic               b_valid_reg;
    asd_ctl_t           b_ctl_reg;
    logic [MAG_W-1:0]   b_sq_x_reg;
    logic [MAG_W-1:0]   b_sq_y_reg;
    logic [MAG_W-1:0]   b_sq_z_reg;

    logic               c_valid_reg;
    asd_ctl_t           c_ctl_reg;
    logic [SUM_W-1:0]   c_dividend_reg;

    logic [MAG_W-1:0]   tap_reg [WINDOW_LEN];
    logic [SUM_W-1:0]   sum_reg;

    logic               a_ready;
    logic               b_ready;
    logic               c_ready;
    logic signed [MAG_W-1:0] sq_x;
    logic signed [MAG_W-1:0] sq_y;
    logic signed [MAG_W-1:0] sq_z;
    logic [MAG_W-1:0]   mag;
    logic [SUM_W-1:0]   sum_next;
    logic               b_is_sample;
    logic               window_load;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // A square of a 16-bit value is at most 2^30, so 32 signed bits hold it exactly.
    assign sq_x = MAG_W'(a_x_reg) * MAG_W'(a_x_reg);
    assign sq_y = MAG_W'(a_y_reg) * MAG_W'(a_y_reg);
    assign sq_z = MAG_W'(a_z_reg) * MAG_W'(a_z_reg);

    // Three squares sum to at most 3 * 2^30, which still fits 32 unsigned bits.
    assign mag         = b_sq_x_reg + b_sq_y_reg + b_sq_z_reg;
    assign sum_next    = sum_reg - SUM_W'(tap_reg[WINDOW_LEN-1]) + SUM_W'(mag);
    assign b_is_sample = (b_ctl_reg.req_type == REQ_SAMPLE);
    assign window_load = c_ready && b_valid_reg && b_is_sample;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_ctl_reg <= in_ctl;
            a_x_reg   <= accel_x;
            a_y_reg   <= accel_y;
            a_z_reg   <= accel_z;
        end
        if (b_ready) begin
            b_ctl_reg  <= a_ctl_reg;
            b_sq_x_reg <= $unsigned(sq_x);
            b_sq_y_reg <= $unsigned(sq_y);
            b_sq_z_reg <= $unsigned(sq_z);
        end
        if (c_ready) begin
            c_ctl_reg <= b_ctl_reg;
            // Non-sample words divide a zero and so report a zero mean.
            c_dividend_reg <= b_is_sample ? (sum_next + ROUND_HALF) : '0;
        end
    end

    // The window is a shift line: the last tap is the value written WINDOW_LEN samples ago.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                tap_reg[i] <= '0;
            end
            sum_reg <= '0;
        end else if (window_load) begin
            tap_reg[0] <= mag;
            for (int i = 1; i < WINDOW_LEN; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
            sum_reg <= sum_next;
        end
    end

    assign out_valid    = c_valid_reg;
    assign out_ctl      = c_ctl_reg;
    assign out_dividend = c_dividend_reg;

endmodule

@@ rtl/core/asd_div.sv @@
// Division of the rounded window sum by the window length: reciprocal multiply and
// residue correction in three pipeline stages. Depends on asd_pkg.
`timescale 1ns / 1ps

module asd_div #(
    parameter int WINDOW_LEN = asd_pkg::WINDOW_LEN_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  asd_pkg::asd_ctl_t                         in_ctl,
    input  logic [asd_pkg::sum_width(WINDOW_LEN)-1:0] in_dividend,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output asd_pkg::asd_ctl_t                         out_ctl,
    output logic [asd_pkg::QUO_W-1:0]                 out_quotient
);
    import asd_pkg::*;

    localparam int SUM_W = sum_width(WINDOW_LEN);
    // One spare top bit keeps the upper dividend slice nonempty for a window of one.
    localparam int XW    = SUM_W + 1;
    localparam int PLW   = 2 * QUO_W;
    localparam int PW    = XW + QUO_W;
    // With this shift the truncated reciprocal fits 32 bits and the estimate is low by
    // at most two, which the residue check below puts right.
    localparam int SHIFT = QUO_W - 1 + $clog2(WINDOW_LEN);
    localparam logic [QUO_W-1:0] RECIP = QUO_W'((64'd1 << SHIFT) / WINDOW_LEN);
    // The residue of the estimate stays below three divisors.
    localparam int RW    = $clog2(3 * WINDOW_LEN);
    localparam logic [RW-1:0] NR  = RW'(WINDOW_LEN);
    localparam logic [RW-1:0] NR2 = RW'(2 * WINDOW_LEN);

    logic             v0_reg;
    asd_ctl_t         ctl0_reg;
    logic [PLW-1:0]   plo0_reg;
    logic [XW-1:0]    phi0_reg;
    logic [RW-1:0]    xl0_reg;

    logic             v1_reg;
    asd_ctl_t         ctl1_reg;
    logic [QUO_W-1:0] qe1_reg;
    logic [RW-1:0]    xl1_reg;

    logic             v2_reg;
    asd_ctl_t         ctl2_reg;
    logic [QUO_W-1:0] q2_reg;

    logic             rdy0;
    logic             rdy1;
    logic             rdy2;
    logic [XW-1:0]    x_ext;
    logic [PLW-1:0]   p_lo;
    logic [XW-1:0]    p_hi;
    logic [PW-1:0]    prod;
    logic [QUO_W-1:0] q_est;
    logic [RW-1:0]    resid;
    logic [QUO_W-1:0] q_fix;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign in_ready = rdy0;

    // The product is split at bit 32 so that no multiplier is wider than 32 by 32.
    assign x_ext = XW'(in_dividend);
    assign p_lo  = PLW'(x_ext[QUO_W-1:0]) * PLW'(RECIP);
    assign p_hi  = XW'(x_ext[XW-1:QUO_W]) * XW'(RECIP);

    assign prod  = PW'(plo0_reg) + (PW'(phi0_reg) << QUO_W);
    assign q_est = QUO_W'(prod >> SHIFT);

    // Only the low bits of the dividend and the estimate are needed for the residue.
    assign resid = xl1_reg - RW'(qe1_reg[RW-1:0] * NR);
    assign q_fix = qe1_reg + QUO_W'(resid >= NR) + QUO_W'(resid >= NR2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy0) begin
                v0_reg <= in_valid;
            end
            if (rdy1) begin
                v1_reg <= v0_reg;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy0) begin
            ctl0_reg <= in_ctl;
            plo0_reg <= p_lo;
            phi0_reg <= p_hi;
            xl0_reg  <= x_ext[RW-1:0];
        end
        if (rdy1) begin
            ctl1_reg <= ctl0_reg;
            qe1_reg  <= q_est;
            xl1_reg  <= xl0_reg;
        end
        if (rdy2) begin
            ctl2_reg <= ctl1_reg;
            q2_reg   <= q_fix;
        end
    end

    assign out_valid    = v2_reg;
    assign out_ctl      = ctl2_reg;
    assign out_quotient = q2_reg;

endmodule

@@ rtl/core/asd_count.sv @@
// Result stage: threshold crossing detection, step counter and the result register.
// Depends on asd_pkg.
`timescale 1ns / 1ps

module asd_count (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [31:0]                   threshold_sq,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  asd_pkg::asd_ctl_t             in_ctl,
    input  logic [asd_pkg::QUO_W-1:0]     in_mean,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [asd_pkg::COUNT_W-1:0]   step_total,
    output logic                          step_seen,
    output logic [asd_pkg::QUO_W-1:0]     mean_mag_sq
);
    import asd_pkg::*;

    localparam int ADJ_W = COUNT_W + 2;

    logic               out_valid_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               was_below_reg;
    logic               seen_reg;
    logic [QUO_W-1:0]   mean_reg;

    logic               load;
    logic [COUNT_W-1:0] count_next;
    logic               was_below_next;
    logic               seen_next;
    logic [QUO_W-1:0]   mean_next;
    logic signed [ADJ_W-1:0] adj_sum;

    assign in_ready = !out_valid_reg || out_ready;
    assign load     = in_ready && in_valid;

    assign adj_sum = $signed({2'b00, count_reg}) + ADJ_W'($signed(in_ctl.adjust_amount));

    always_comb begin
        count_next     = count_reg;
        was_below_next = was_below_reg;
        seen_next      = 1'b0;
        mean_next      = '0;
        case (in_ctl.req_type)
            REQ_SAMPLE: begin
                mean_next = in_mean;
                if (in_mean > threshold_sq) begin
                    // Only the rising crossing counts; the count sticks at its maximum.
                    if (was_below_reg) begin
                        if (count_reg != COUNT_MAX) begin
                            count_next = count_reg + 1'b1;
                        end
                        seen_next      = 1'b1;
                        was_below_next = 1'b0;
                    end
                end else begin
                    was_below_next = 1'b1;
                end
            end
            REQ_ADJUST: begin
                if (adj_sum[ADJ_W-1]) begin
                    count_next = '0;
                end else if (adj_sum[COUNT_W]) begin
                    count_next = COUNT_MAX;
                end else begin
                    count_next = adj_sum[COUNT_W-1:0];
                end
            end
            REQ_CLEAR: begin
                count_next = '0;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            was_below_reg <= 1'b1;
        end else begin
            if (in_ready) begin
                out_valid_reg <= in_valid;
            end
            if (load) begin
                count_reg     <= count_next;
                was_below_reg <= was_below_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            seen_reg <= seen_next;
            mean_reg <= mean_next;
        end
    end

    // The counter only moves when a result is loaded, so it doubles as the reported total.
    assign out_valid   = out_valid_reg;
    assign step_total  = count_reg;
    assign step_seen   = seen_reg;
    assign mean_mag_sq = mean_reg;

endmodule

@@ rtl/core/accel_step_detector.sv @@
// Step detector for a three-axis accelerometer: takes one word per cycle while the output
// is not stalled and gives one result word per input word, in order. Each word passes seven
// register stages (input, squaring, window update, three divider stages, result) before its
// result can be taken; throughput is one word per cycle when the output is not stalled, set
// by the running-sum update of the window and by the pipelined reciprocal multiply that
// divides the window sum. Sample words update the window of the last WINDOW_LEN squared
// magnitudes and report its rounded mean; a step is counted when the mean rises above
// threshold_sq after having been at or below it. Adjust words add a signed amount to the
// count (floored at zero, saturated at the maximum), clear words zero it. Write threshold_sq
// only while no word is in flight. Depends on asd_pkg and the asd_* modules.
`timescale 1ns / 1ps

module accel_step_detector #(
    parameter int WINDOW_LEN = asd_pkg::WINDOW_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32], adjust_amount [79:48]
    input  logic [79:0] s_tdata,
    // req_type [1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // step_total [30:0], step_seen [31], mean_mag_sq [63:32]
    output logic [63:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import asd_pkg::*;

    localparam int SUM_W = sum_width(WINDOW_LEN);

    logic [31:0]        thr_reg;

    asd_ctl_t           s_ctl;
    logic               f_valid;
    logic               f_ready;
    asd_ctl_t           f_ctl;
    logic [SUM_W-1:0]   f_dividend;
    logic               d_valid;
    logic               d_ready;
    asd_ctl_t           d_ctl;
    logic [QUO_W-1:0]   d_quotient;
    logic [COUNT_W-1:0] step_total;
    logic               step_seen;
    logic [QUO_W-1:0]   mean_mag_sq;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESHOLD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            thr_reg <= cfg_data;
        end
    end

    assign s_ctl.req_type      = s_tuser;
    assign s_ctl.adjust_amount = $signed(s_tdata[79:48]);

    asd_front #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_ctl      (s_ctl),
        .accel_x     ($signed(s_tdata[15:0])),
        .accel_y     ($signed(s_tdata[31:16])),
        .accel_z     ($signed(s_tdata[47:32])),
        .out_valid   (f_valid),
        .out_ready   (f_ready),
        .out_ctl     (f_ctl),
        .out_dividend(f_dividend)
    );

    asd_div #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (f_valid),
        .in_ready    (f_ready),
        .in_ctl      (f_ctl),
        .in_dividend (f_dividend),
        .out_valid   (d_valid),
        .out_ready   (d_ready),
        .out_ctl     (d_ctl),
        .out_quotient(d_quotient)
    );

    asd_count u_count (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .threshold_sq(thr_reg),
        .in_valid    (d_valid),
        .in_ready    (d_ready),
        .in_ctl      (d_ctl),
        .in_mean     (d_quotient),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .step_total  (step_total),
        .step_seen   (step_seen),
        .mean_mag_sq (mean_mag_sq)
    );

    assign m_tdata = {mean_mag_sq, step_seen, step_total};

    // A reported step must come from a mean above the threshold in force.
    a_step_above_thr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && step_seen |-> mean_mag_sq > thr_reg)
        else $error("step reported with mean at or below threshold");

    // A step never leaves the count at zero.
    a_step_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && step_seen |-> step_total != '0)
        else $error("step reported with zero count");

    // The input side only stalls when every stage is full behind a stalled output.
    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while the output is free");

endmodule
